### hdl/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg
// shared types, codes and constants of the letter and bigram histogram
// ----------------------------------------------------------------------------
package lbh_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int LETTERS            = 26;
  localparam int PAIRS              = LETTERS * LETTERS;
  localparam int LETTER_IDX_BITS    = $clog2(LETTERS);
  localparam int PAIR_IDX_BITS      = $clog2(PAIRS);
  localparam int QUEUE_DEPTH        = 4;
  localparam int OUT_BITS           = 32;

  localparam logic [1:0] OP_TEXT        = 2'd0;
  localparam logic [1:0] OP_READ_LETTER = 2'd1;
  localparam logic [1:0] OP_READ_PAIR   = 2'd2;
  localparam logic [1:0] OP_CLEAR       = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [LETTER_IDX_BITS-1:0] LAST_LETTER = LETTER_IDX_BITS'(LETTERS - 1);
  localparam logic [PAIR_IDX_BITS-1:0]   LAST_PAIR   = PAIR_IDX_BITS'(PAIRS - 1);

  typedef enum logic [1:0] {
    KIND_TEXT,
    KIND_READ_LETTER,
    KIND_READ_PAIR,
    KIND_CLEAR
  } lbh_kind_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } lbh_state_t;

  typedef struct packed {
    lbh_kind_t                  kind;
    logic [LETTER_IDX_BITS-1:0] letter_idx;
    logic [PAIR_IDX_BITS-1:0]   pair_idx;
    logic                       letter_en;
    logic                       pair_en;
    logic                       zero;
  } lbh_item_t;

  typedef struct packed {
    logic clearing;
  } lbh_status_t;

endpackage

### hdl/lbh_ram.sv
// ----------------------------------------------------------------------------
// lbh_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/lbh_front.sv
// ----------------------------------------------------------------------------
// lbh_front
// accepts commands, folds case, classifies letters and builds table indexes
// ----------------------------------------------------------------------------
module lbh_front import lbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  text_byte,
  input  logic [4:0]  first_letter,
  input  logic [4:0]  second_letter,
  input  lbh_status_t status,
  input  logic        q_full,
  output logic        push,
  output lbh_item_t   item
);

  logic                       prev_letter;
  logic [LETTER_IDX_BITS-1:0] prev_idx;
  logic [7:0]                 folded;
  logic                       cur_letter;
  logic [LETTER_IDX_BITS-1:0] cur_idx;
  logic [4:0]                 pair_a;
  logic [4:0]                 pair_b;
  logic [PAIR_IDX_BITS-1:0]   pair_idx;

  assign busy = q_full || status.clearing;
  assign push = start && !busy;

  always_comb begin
    folded = text_byte;
    if (text_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      folded = text_byte - CASE_OFFSET;
    end
    cur_letter = folded inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
    cur_idx    = LETTER_IDX_BITS'(folded - CHAR_UPPER_A);
  end

  // one index multiplier shared by text pairs and pair queries
  always_comb begin
    if (op == OP_TEXT) begin
      pair_a = 5'(prev_idx);
      pair_b = 5'(cur_idx);
    end else begin
      pair_a = first_letter;
      pair_b = second_letter;
    end
    pair_idx = PAIR_IDX_BITS'(PAIR_IDX_BITS'(pair_a) * PAIR_IDX_BITS'(LETTERS))
             + PAIR_IDX_BITS'(pair_b);
  end

  always_comb begin
    item            = '0;
    item.letter_idx = first_letter;
    item.pair_idx   = pair_idx;
    case (op)
      OP_TEXT: begin
        item.kind       = KIND_TEXT;
        item.letter_idx = cur_idx;
        item.letter_en  = cur_letter;
        item.pair_en    = cur_letter && prev_letter;
      end
      OP_READ_LETTER: begin
        item.kind = KIND_READ_LETTER;
        item.zero = first_letter > 5'(LAST_LETTER);
      end
      OP_READ_PAIR: begin
        item.kind = KIND_READ_PAIR;
        item.zero = (first_letter > 5'(LAST_LETTER)) || (second_letter > 5'(LAST_LETTER));
      end
      default: begin
        item.kind = KIND_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_letter <= 1'b0;
      prev_idx    <= '0;
    end else if (push) begin
      if (op == OP_TEXT) begin
        prev_letter <= cur_letter;
        prev_idx    <= cur_idx;
      end else if (op == OP_CLEAR) begin
        prev_letter <= 1'b0;
      end
    end
  end

endmodule

### hdl/lbh_queue.sv
// ----------------------------------------------------------------------------
// lbh_queue
// short fifo of classified transactions between front and back
// ----------------------------------------------------------------------------
module lbh_queue import lbh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lbh_item_t item_in,
  input  logic      pop,
  output lbh_item_t head,
  output logic      empty,
  output logic      full
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  lbh_item_t           entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign head  = entries[rd_ptr];
  assign empty = fill == '0;
  assign full  = fill == CNT_BITS'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/lbh_back.sv
// ----------------------------------------------------------------------------
// lbh_back
// executes transactions against the letter and pair count tables
// ----------------------------------------------------------------------------
module lbh_back import lbh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  lbh_item_t           head,
  input  logic                empty,
  output logic                pop,
  output lbh_status_t         status,
  output logic                count_valid,
  output logic [OUT_BITS-1:0] count
);

  lbh_state_t state;
  lbh_state_t state_next;
  lbh_item_t  cur;

  logic [PAIR_IDX_BITS-1:0]   sweep;
  logic [LETTER_IDX_BITS-1:0] letter_wr_addr;
  logic [PAIR_IDX_BITS-1:0]   pair_wr_addr;
  logic [COUNT_BITS-1:0]      letter_wr_data;
  logic [COUNT_BITS-1:0]      pair_wr_data;
  logic [COUNT_BITS-1:0]      letter_rd;
  logic [COUNT_BITS-1:0]      pair_rd;
  logic                       letter_we;
  logic                       pair_we;
  logic                       result;
  logic [COUNT_BITS-1:0]      sel_rd;
  logic [63:0]                sel_wide;
  logic [OUT_BITS-1:0]        result_value;

  lbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(LETTERS)) u_letter_ram (
    .clk     (clk),
    .wr_en   (letter_we),
    .wr_addr (letter_wr_addr),
    .wr_data (letter_wr_data),
    .rd_addr (head.letter_idx),
    .rd_data (letter_rd)
  );

  lbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIRS)) u_pair_ram (
    .clk     (clk),
    .wr_en   (pair_we),
    .wr_addr (pair_wr_addr),
    .wr_data (pair_wr_data),
    .rd_addr (head.pair_idx),
    .rd_data (pair_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep == LAST_PAIR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = (cur.kind == KIND_CLEAR) ? ST_SWEEP : ST_IDLE;
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  // saturating read out of wide counters
  always_comb begin
    sel_rd       = (cur.kind == KIND_READ_PAIR) ? pair_rd : letter_rd;
    sel_wide     = 64'(sel_rd);
    result_value = (|sel_wide[63:OUT_BITS]) ? '1 : sel_wide[OUT_BITS-1:0];
    if (cur.zero) begin
      result_value = '0;
    end
  end

  always_comb begin
    pop             = 1'b0;
    status.clearing = 1'b0;
    letter_we       = 1'b0;
    pair_we         = 1'b0;
    result          = 1'b0;
    letter_wr_addr  = cur.letter_idx;
    pair_wr_addr    = cur.pair_idx;
    letter_wr_data  = (letter_rd == '1) ? letter_rd : letter_rd + 1'b1;
    pair_wr_data    = (pair_rd == '1) ? pair_rd : pair_rd + 1'b1;
    case (state)
      ST_SWEEP: begin
        status.clearing = 1'b1;
        pair_we         = 1'b1;
        pair_wr_addr    = sweep;
        pair_wr_data    = '0;
        letter_we       = sweep <= PAIR_IDX_BITS'(LAST_LETTER);
        letter_wr_addr  = LETTER_IDX_BITS'(sweep);
        letter_wr_data  = '0;
      end
      ST_IDLE: begin
        pop = !empty;
      end
      ST_EXEC: begin
        letter_we = (cur.kind == KIND_TEXT) && cur.letter_en;
        pair_we   = (cur.kind == KIND_TEXT) && cur.pair_en;
        result    = (cur.kind == KIND_READ_LETTER) || (cur.kind == KIND_READ_PAIR);
        status.clearing = cur.kind == KIND_CLEAR;
      end
      default: begin
        status.clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep       <= '0;
      count_valid <= 1'b0;
    end else begin
      state       <= state_next;
      count_valid <= result;
      if (state == ST_SWEEP) begin
        sweep <= sweep + 1'b1;
      end else begin
        sweep <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (result) begin
      count <= result_value;
    end
  end

endmodule

### hdl/letter_bigram_histogram.sv
// ----------------------------------------------------------------------------
// letter_bigram_histogram
// letter and ordered letter-pair frequency counter for a text byte stream
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. A front
// end folds case and classifies the byte or query into a four-entry queue; a
// back end pops each queued transaction in its idle state with a registered
// read of the letter and pair count rams and finishes it in its exec state,
// where a text byte writes the counts back incremented. Read queries return
// count with count_valid high for exactly one cycle; the receiver cannot
// stall, so results must be taken as they appear. After reset and after
// every clear command the back end sweeps both tables to zero, during
// which busy stays high. Counts saturate at their maximum.
module letter_bigram_histogram import lbh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [7:0]          text_byte,
  input  logic [4:0]          first_letter,
  input  logic [4:0]          second_letter,
  output logic                count_valid,
  output logic [OUT_BITS-1:0] count
);

  lbh_status_t status;
  lbh_item_t   item;
  lbh_item_t   head;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  lbh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .text_byte     (text_byte),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .status        (status),
    .q_full        (q_full),
    .push          (push),
    .item          (item)
  );

  lbh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item_in (item),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  lbh_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .status      (status),
    .count_valid (count_valid),
    .count       (count)
  );

  // tables are swept right after reset
  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // each transaction has a read state and a write state, so result strobes never come back to back
  a_strobe_spacing: assert property (@(posedge clk) disable iff (rst)
    count_valid |=> !count_valid)
    else $error("result strobes in consecutive cycles");

  // the queue never takes a push while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_full && !pop) |=> q_full || $past(pop))
    else $error("queue lost an entry while full");

endmodule

### sim/histogram_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_checker
// watches the command and result channels of the letter and bigram histogram,
// keeps its own letter and pair tallies, and compares every returned count
// against the value predicted when its query transaction was taken
// ----------------------------------------------------------------------------
module histogram_checker import lbh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          op,
  input  logic [7:0]          text_byte,
  input  logic [4:0]          first_letter,
  input  logic [4:0]          second_letter,
  input  logic                count_valid,
  input  logic [OUT_BITS-1:0] count,
  output int                  mismatches,
  output int                  pending
);

  localparam logic [63:0] COUNT_CAP = {64{1'b1}} >> (64 - COUNT_BITS);

  logic [63:0]         letter_tally [LETTERS];
  logic [63:0]         pair_tally [PAIRS];
  logic [7:0]          last_byte;
  logic                last_seen;
  logic [OUT_BITS-1:0] expected_counts [$];

  function automatic logic [63:0] bumped(logic [63:0] v);
    return (v < COUNT_CAP) ? v + 64'd1 : v;
  endfunction

  function automatic logic [OUT_BITS-1:0] shown(logic [63:0] v);
    return (v > 64'hffff_ffff) ? {OUT_BITS{1'b1}} : v[OUT_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] letter_reading(logic [4:0] idx);
    if (idx < LETTERS) return shown(letter_tally[idx]);
    return '0;
  endfunction

  function automatic logic [OUT_BITS-1:0] pair_reading(logic [4:0] a, logic [4:0] b);
    if (a < LETTERS && b < LETTERS) return shown(pair_tally[int'(a) * LETTERS + int'(b)]);
    return '0;
  endfunction

  task automatic clear_tallies();
    for (int i = 0; i < LETTERS; i++) letter_tally[i] = '0;
    for (int i = 0; i < PAIRS; i++) pair_tally[i] = '0;
    last_byte = '0;
    last_seen = 1'b0;
  endtask

  task automatic take_text(logic [7:0] raw);
    logic [7:0] folded;
    int cur;
    int prev;
    folded = raw;
    if (raw >= CHAR_LOWER_A && raw <= CHAR_LOWER_Z) folded = raw - CASE_OFFSET;
    if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
      cur = int'(folded) - int'(CHAR_UPPER_A);
      letter_tally[cur] = bumped(letter_tally[cur]);
      // pair only when the previous byte was a letter too
      if (last_seen && last_byte >= CHAR_UPPER_A && last_byte <= CHAR_UPPER_Z) begin
        prev = int'(last_byte) - int'(CHAR_UPPER_A);
        pair_tally[prev * LETTERS + cur] = bumped(pair_tally[prev * LETTERS + cur]);
      end
    end
    last_byte = folded;
    last_seen = 1'b1;
  endtask

  initial clear_tallies();

  always @(posedge clk) begin : watch
    logic [OUT_BITS-1:0] wanted;
    if (rst) begin
      clear_tallies();
      expected_counts.delete();
      mismatches <= 0;
    end else begin
      if (count_valid === 1'b1) begin
        if (expected_counts.size() == 0) begin
          $error("count: no query pending, expected none, actual %0d", count);
          mismatches <= mismatches + 1;
        end else begin
          wanted = expected_counts.pop_front();
          if (count !== wanted) begin
            $error("count mismatch: expected %0d, actual %0d", wanted, count);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        case (op)
          OP_TEXT:        take_text(text_byte);
          OP_READ_LETTER: expected_counts.push_back(letter_reading(first_letter));
          OP_READ_PAIR:   expected_counts.push_back(pair_reading(first_letter, second_letter));
          OP_CLEAR:       clear_tallies();
          default:        ;
        endcase
      end
    end
    pending <= expected_counts.size();
  end

endmodule

### sim/tb_letter_bigram_histogram.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_letter_bigram_histogram
// drives text, query and clear transactions into the letter and bigram
// histogram with random gaps, and gives the verdict from the checker
// ----------------------------------------------------------------------------
module tb_letter_bigram_histogram;
  import lbh_pkg::*;

  localparam int ITEMS      = 450;
  localparam int IDLE_LIMIT = 4000;

  logic                clk;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic                busy;
  logic [1:0]          op            = OP_TEXT;
  logic [7:0]          text_byte     = '0;
  logic [4:0]          first_letter  = '0;
  logic [4:0]          second_letter = '0;
  logic                count_valid;
  logic [OUT_BITS-1:0] count;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  bit steady      = 1'b0;

  letter_bigram_histogram uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .text_byte     (text_byte),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .count_valid   (count_valid),
    .count         (count)
  );

  histogram_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .text_byte     (text_byte),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .count_valid   (count_valid),
    .count         (count),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || count_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a rising edge, returns at the edge that takes the transaction
  task automatic send_command(logic [1:0] c, logic [7:0] b, logic [4:0] a, logic [4:0] z);
    int gap;
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) gap = 0;
    else if (r < 93) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    op            <= c;
    text_byte     <= b;
    first_letter  <= a;
    second_letter <= z;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic send_text(logic [7:0] b);
    send_command(OP_TEXT, b, 5'($urandom_range(31)), 5'($urandom_range(31)));
  endtask

  task automatic ask_letter(logic [4:0] a);
    send_command(OP_READ_LETTER, 8'($urandom_range(255)), a, 5'($urandom_range(31)));
  endtask

  task automatic ask_pair(logic [4:0] a, logic [4:0] z);
    send_command(OP_READ_PAIR, 8'($urandom_range(255)), a, z);
  endtask

  task automatic random_command();
    int r;
    int s;
    logic [7:0] b;
    logic [4:0] a;
    logic [4:0] z;
    r = $urandom_range(99);
    s = $urandom_range(99);
    if (r < 1) begin
      send_command(OP_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                   5'($urandom_range(31)));
    end else if (r < 60) begin
      if (s < 85) begin
        // mostly a narrow alphabet so that pairs repeat
        b = (s < 70) ? 8'($urandom_range(5)) : 8'($urandom_range(25));
        b = b + ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A);
      end else begin
        b = 8'($urandom_range(255));
      end
      send_text(b);
    end else if (r < 80) begin
      a = (s < 90) ? 5'($urandom_range(25)) : 5'($urandom_range(31, 26));
      ask_letter(a);
    end else begin
      if (s < 60) begin
        a = 5'($urandom_range(5));
        z = 5'($urandom_range(5));
      end else if (s < 90) begin
        a = 5'($urandom_range(25));
        z = 5'($urandom_range(25));
      end else begin
        a = 5'($urandom_range(31));
        z = 5'($urandom_range(31, 26));
        if ($urandom_range(1)) begin
          a = z;
          z = 5'($urandom_range(31));
        end
      end
      ask_pair(a, z);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // case folding, pairs, non-letters at the edges of the letter ranges
    send_text(CHAR_LOWER_A);
    send_text(CHAR_UPPER_A + 8'd1);
    ask_pair(5'd0, 5'd1);
    ask_letter(5'd0);
    send_text(CHAR_UPPER_A - 8'd1);
    send_text(CHAR_UPPER_Z);
    send_text(CHAR_UPPER_Z + 8'd1);
    send_text(CHAR_LOWER_A - 8'd1);
    send_text(CHAR_LOWER_Z);
    send_text(CHAR_LOWER_Z + 8'd1);
    send_text(8'h00);
    send_text(8'hff);
    send_text(CHAR_UPPER_A | 8'h80);
    send_text(CHAR_LOWER_A | 8'h80);
    send_text(CHAR_UPPER_Z);
    send_text(CHAR_LOWER_Z);
    ask_letter(LAST_LETTER);
    ask_letter(5'd26);
    ask_letter(5'd31);
    ask_pair(LAST_LETTER, LAST_LETTER);
    ask_pair(5'd26, 5'd0);
    ask_pair(5'd0, 5'd31);
    send_command(OP_CLEAR, 8'hff, 5'd31, 5'd31);
    ask_letter(5'd0);
    send_text(CHAR_LOWER_A + 8'd16);
    ask_pair(5'd25, 5'd16);
    ask_letter(5'd16);

    for (int i = 0; i < ITEMS; i++) begin
      if ($urandom_range(39) == 0) steady = ~steady;
      random_command();
    end
    start <= 1'b0;

    do @(negedge clk); while (pending != 0 || busy);
    repeat (10) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
